### sv/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared constants and types for the restriction site scanner.
// ----------------------------------------------------------------------------
package rss_pkg;

  // Default sizing
  localparam int unsigned DefMaxSeqLen    = 16777216;
  localparam int unsigned DefMaxSiteBases = 32;

  // Configuration register file
  localparam int unsigned PatternW = 64;
  localparam int unsigned LengthW  = 6;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] RegSitePattern = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSiteLength  = 1'b1;

  localparam logic [LengthW-1:0] SiteLengthRst = 6'd4;

  // Input payload
  localparam int unsigned BaseW     = 2;
  localparam int unsigned InTdataW  = 8;

  // Up to three boundaries come out of one base
  localparam int unsigned NumSlots = 3;

  // Control side of one result bundle
  typedef struct packed {
    logic [1:0] count;    // number of boundaries in the bundle
    logic       has_end;  // bundle closes the sequence
  } rss_bundle_ctl_t;

endpackage

### sv/restriction_site_scanner.sv
// ----------------------------------------------------------------------------
// restriction_site_scanner
// Streams 2-bit DNA bases and reports cut boundaries: 0, every start of the
// configured site (not on the last base), then sequence length and length+1.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tdata[1:0] base, tlast last_of_sequence
//  m_axis   | out       | tdata boundary_offset, tlast last
//  cfg      | in        | index 0 site_pattern, index 1 site_length
//
//  A base waits in the input register, then its boundaries load into the
//  result register; a new base is taken every cycle unless the result
//  register is busy. A base with several boundaries holds the result register
//  until each has gone out on the single output port; bases without one pass
//  freely. Reset clears the window, counter and handshake state and sets the
//  config registers to their defaults; the data registers are not reset.
// ----------------------------------------------------------------------------
module restriction_site_scanner import rss_pkg::*; #(
  parameter int unsigned MAX_SEQ_LEN    = DefMaxSeqLen,
  parameter int unsigned MAX_SITE_BASES = DefMaxSiteBases,
  localparam int unsigned CntW     = $clog2(MAX_SEQ_LEN + 1),
  localparam int unsigned OffW     = $clog2(MAX_SEQ_LEN + 2),
  localparam int unsigned OutTdataW = ((OffW + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [InTdataW-1:0]   s_axis_tdata_i,   // [1:0] base
  input  logic                  s_axis_tlast_i,
  // Output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OutTdataW-1:0]  m_axis_tdata_o,   // [OffW-1:0] boundary_offset
  output logic                  m_axis_tlast_o,
  // Configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [PatternW-1:0]   cfg_data_i
);

  logic [PatternW-1:0]           site_pattern_q;
  logic [LengthW-1:0]            site_length_q;
  logic                          in_valid_q;
  logic [BaseW-1:0]              in_base_q;
  logic                          in_last_q;
  logic                          advance, load, res_free, in_xfer;
  rss_bundle_ctl_t               bundle_ctl;
  logic [NumSlots-1:0][OffW-1:0] bundle_off;
  logic [OffW-1:0]               out_off;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_pattern_q <= '0;
      site_length_q  <= SiteLengthRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegSitePattern: site_pattern_q <= cfg_data_i;
        RegSiteLength:  site_length_q  <= cfg_data_i[LengthW-1:0];
        default: ;
      endcase
    end
  end

  // Input register; a base moves on when its bundle is empty or fits
  assign advance         = in_valid_q && ((bundle_ctl.count == 2'd0) || res_free);
  assign load            = advance && (bundle_ctl.count != 2'd0);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_base_q <= s_axis_tdata_i[BaseW-1:0];
      in_last_q <= s_axis_tlast_i;
    end
  end

  rss_core #(
    .MAX_SEQ_LEN    (MAX_SEQ_LEN),
    .MAX_SITE_BASES (MAX_SITE_BASES),
    .CNT_W          (CntW),
    .OFF_W          (OffW)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .site_pattern_i (site_pattern_q),
    .site_length_i  (site_length_q),
    .base_i         (in_base_q),
    .last_i         (in_last_q),
    .advance_i      (advance),
    .ctl_o          (bundle_ctl),
    .slot_off_o     (bundle_off)
  );

  rss_result #(
    .OFF_W (OffW)
  ) u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .ctl_i      (bundle_ctl),
    .slot_off_i (bundle_off),
    .free_o     (res_free),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .off_o      (out_off),
    .last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OutTdataW'(out_off);

endmodule

### sv/rss_core.sv
// ----------------------------------------------------------------------------
// rss_core
// Rolling base window, position counter and site compare. Builds the
// boundary bundle for the base held in the input register.
// ----------------------------------------------------------------------------
module rss_core import rss_pkg::*; #(
  parameter int unsigned MAX_SEQ_LEN    = DefMaxSeqLen,
  parameter int unsigned MAX_SITE_BASES = DefMaxSiteBases,
  parameter int unsigned CNT_W          = $clog2(MAX_SEQ_LEN + 1),
  parameter int unsigned OFF_W          = $clog2(MAX_SEQ_LEN + 2)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [PatternW-1:0]              site_pattern_i,
  input  logic [LengthW-1:0]               site_length_i,
  input  logic [BaseW-1:0]                 base_i,
  input  logic                             last_i,
  input  logic                             advance_i,
  output rss_bundle_ctl_t                  ctl_o,
  output logic [NumSlots-1:0][OFF_W-1:0]   slot_off_o
);

  localparam int unsigned WinW = 2 * MAX_SITE_BASES;
  localparam logic [CNT_W-1:0] Lim = CNT_W'(MAX_SEQ_LEN);

  logic [WinW-1:0]    win_q, win_d, win_next;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [LengthW-1:0] eff_len;
  logic               is_first, site_hit, bits_ok, upper_ok, pos_ok;
  logic [OFF_W-1:0]   hit_off, len, len_p1;

  // Effective site length: 0 acts as 1, clamp at the window size
  always_comb begin
    if (site_length_i == '0) begin
      eff_len = LengthW'(1);
    end else if (32'(site_length_i) > MAX_SITE_BASES) begin
      eff_len = LengthW'(MAX_SITE_BASES);
    end else begin
      eff_len = site_length_i;
    end
  end

  assign win_next = (win_q << 2) | WinW'(base_i);

  // Masked compare; pattern bits above the site must be clear
  always_comb begin
    bits_ok = 1'b1;
    for (int i = 0; i < WinW; i++) begin
      if (32'(i) < 2 * 32'(eff_len)) begin
        if (win_next[i] != site_pattern_i[i]) bits_ok = 1'b0;
      end else begin
        if (site_pattern_i[i]) bits_ok = 1'b0;
      end
    end
  end

  assign upper_ok = (site_pattern_i >> WinW) == '0;
  assign pos_ok   = (pos_q < Lim) && (32'(pos_q) >= 32'(eff_len));
  assign site_hit = !last_i && pos_ok && bits_ok && upper_ok;
  assign is_first = (pos_q == '0);

  assign hit_off = OFF_W'(32'(pos_q) + 32'd1 - 32'(eff_len));
  assign len     = (pos_q == Lim) ? OFF_W'(Lim) : OFF_W'(32'(pos_q) + 32'd1);
  assign len_p1  = OFF_W'(32'(len) + 32'd1);

  // Bundle layout in delivery order
  always_comb begin
    ctl_o.has_end = last_i;
    if (is_first) begin
      ctl_o.count   = last_i ? 2'd3 : 2'd1;
      slot_off_o[0] = '0;
      slot_off_o[1] = len;
    end else begin
      ctl_o.count   = site_hit ? 2'd1 : (last_i ? 2'd2 : 2'd0);
      slot_off_o[0] = site_hit ? hit_off : len;
      slot_off_o[1] = len_p1;
    end
    slot_off_o[2] = len_p1;
  end

  // State update when the base leaves the input register
  always_comb begin
    win_d = win_q;
    pos_d = pos_q;
    if (advance_i) begin
      if (last_i) begin
        win_d = '0;
        pos_d = '0;
      end else begin
        win_d = win_next;
        if (pos_q < Lim) pos_d = pos_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      pos_q <= '0;
    end else begin
      win_q <= win_d;
      pos_q <= pos_d;
    end
  end

endmodule

### sv/rss_result.sv
// ----------------------------------------------------------------------------
// rss_result
// Result register: holds one boundary bundle and hands it out one
// boundary per transfer.
// ----------------------------------------------------------------------------
module rss_result import rss_pkg::*; #(
  parameter int unsigned OFF_W = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  rss_bundle_ctl_t                ctl_i,
  input  logic [NumSlots-1:0][OFF_W-1:0] slot_off_i,
  output logic                           free_o,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [OFF_W-1:0]               off_o,
  output logic                           last_o
);

  logic                           valid_q, valid_d;
  logic [1:0]                     idx_q, idx_d;
  rss_bundle_ctl_t                ctl_q;
  logic [NumSlots-1:0][OFF_W-1:0] slot_q;
  logic                           final_slot;

  assign final_slot = (idx_q == ctl_q.count - 2'd1);
  assign free_o     = !valid_q || (ready_i && final_slot);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (valid_q && ready_i) begin
      if (final_slot) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      ctl_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
      if (load_i) ctl_q <= ctl_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) slot_q <= slot_off_i;
  end

  // Output select
  always_comb begin
    case (idx_q)
      2'd0:    off_o = slot_q[0];
      2'd1:    off_o = slot_q[1];
      default: off_o = slot_q[2];
    endcase
  end

  assign valid_o = valid_q;
  assign last_o  = ctl_q.has_end && final_slot;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the restriction site scanner. Bases are streamed in
// bursts with random gaps; the output side stalls at random and at times for
// a long stretch. A cycle-free model tracks the window and position and
// predicts every boundary, which is compared in order against the output.
// ----------------------------------------------------------------------------
module tb_top;
  import rss_pkg::*;

  localparam int unsigned SeqLenCap = DefMaxSeqLen;
  localparam int unsigned SiteCap   = DefMaxSiteBases;
  localparam int unsigned OffW      = $clog2(SeqLenCap + 2);
  localparam int unsigned OutW      = ((OffW + 7) / 8) * 8;

  // Base encodings
  localparam logic [BaseW-1:0] BaseA = 2'd0;
  localparam logic [BaseW-1:0] BaseC = 2'd1;
  localparam logic [BaseW-1:0] BaseG = 2'd2;
  localparam logic [BaseW-1:0] BaseT = 2'd3;

  typedef struct packed {
    logic [BaseW-1:0] base;
    logic             seq_end;
  } base_item_t;

  typedef struct packed {
    logic [OffW-1:0] offset;
    logic            is_last;
  } boundary_t;

  typedef enum logic [1:0] {RxOpen, RxCoin, RxSparse} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InTdataW-1:0] s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutW-1:0]     m_tdata;
  logic                m_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [PatternW-1:0] cfg_data  = '0;

  // Scan model state and register shadows
  logic [63:0]      scan_window  = '0;
  int unsigned      scan_pos     = 0;
  logic [63:0]      site_pat_cfg = '0;
  logic [LengthW-1:0] site_len_cfg = SiteLengthRst;

  base_item_t  pending_bases [$];
  boundary_t   boundary_q [$];
  int unsigned mismatch_count = 0;
  int unsigned bases_accepted = 0;

  // Site used to plant matches into generated sequences
  logic [63:0] plant_site = '0;
  int unsigned plant_len  = 4;

  restriction_site_scanner #(
    .MAX_SEQ_LEN (SeqLenCap)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned eff_site_len(logic [LengthW-1:0] code);
    if (code == 0) return 1;
    if (code > SiteCap) return SiteCap;
    return 32'(code);
  endfunction

  function automatic logic [63:0] site_mask(int unsigned l);
    if (l >= 32) return '1;
    return (64'd1 << (2 * l)) - 64'd1;
  endfunction

  // Append one predicted boundary
  function automatic void add_boundary(logic [OffW-1:0] offset, logic is_last);
    boundary_t item;
    item.offset  = offset;
    item.is_last = is_last;
    boundary_q.insert(boundary_q.size(), item);
  endfunction

  // Append one base to the send queue
  function automatic void add_base(logic [BaseW-1:0] b, logic seq_end);
    base_item_t item;
    item.base    = b;
    item.seq_end = seq_end;
    pending_bases.insert(pending_bases.size(), item);
  endfunction

  // Shift one base into the window and queue the boundaries it yields
  function automatic void scan_base(logic [BaseW-1:0] b, logic seq_end);
    int unsigned p;
    int unsigned l;
    int unsigned n;
    p = scan_pos;
    l = eff_site_len(site_len_cfg);
    scan_window = {scan_window[61:0], b};
    if (p == 0) add_boundary(OffW'(0), 1'b0);
    if (!seq_end && p < SeqLenCap && p >= l &&
        (scan_window & site_mask(l)) == site_pat_cfg)
      add_boundary(OffW'(p + 1 - l), 1'b0);
    if (seq_end) begin
      n = (p + 1 > SeqLenCap) ? SeqLenCap : p + 1;
      add_boundary(OffW'(n), 1'b0);
      add_boundary(OffW'(n + 1), 1'b1);
      scan_window = '0;
      scan_pos = 0;
    end else if (p < SeqLenCap) begin
      scan_pos = p + 1;
    end
  endfunction

  // Input driver: bursts of transfers separated by random gaps
  base_item_t  cur_item;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        scan_base(cur_item.base, cur_item.seq_end);
        bases_accepted <= bases_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_bases.size() != 0) begin
          cur_item = pending_bases.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(InTdataW - BaseW){1'b0}}, cur_item.base};
          s_tlast  <= cur_item.seq_end;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(7) == 0) ? 40 : $urandom_range(12, 1);
            gap_left   = $urandom_range(5);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, triggered periodically by input progress
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 2;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (bases_accepted >= next_hold_at) begin
      hold_left    <= 70;
      next_hold_at <= next_hold_at + 100;
    end
  end

  // Output monitor and stall pattern
  rx_mode_e    rx_mode = RxOpen;
  int unsigned mode_left = 0;
  logic        ready_bit;
  boundary_t   want;

  always @(posedge clk_i) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (boundary_q.size() == 0) begin
          $display("%0t: unexpected boundary, expected none, got offset %0d last %0b",
                   $time, m_tdata[OffW-1:0], m_tlast);
          mismatch_count++;
        end else begin
          want = boundary_q.pop_front();
          if (m_tdata[OffW-1:0] !== want.offset) begin
            $display("%0t: boundary offset expected %0d, got %0d",
                     $time, want.offset, m_tdata[OffW-1:0]);
            mismatch_count++;
          end
          if (m_tlast !== want.is_last) begin
            $display("%0t: boundary last expected %0b, got %0b",
                     $time, want.is_last, m_tlast);
            mismatch_count++;
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(2));
        mode_left = $urandom_range(64, 8);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RxOpen:   ready_bit = 1'b1;
        RxCoin:   ready_bit = 1'($urandom_range(1));
        default:  ready_bit = ($urandom_range(3) == 0);
      endcase
      m_tready <= (hold_left == 0) && ready_bit;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [PatternW-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == RegSitePattern) site_pat_cfg = data;
    else site_len_cfg = data[LengthW-1:0];
  endtask

  // Wait until every base is taken and every boundary has come out
  task automatic wait_idle();
    while (pending_bases.size() != 0 || s_tvalid || boundary_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic queue_bases(string seq);
    logic [BaseW-1:0] b;
    for (int i = 0; i < seq.len(); i++) begin
      case (seq[i])
        "A":     b = BaseA;
        "C":     b = BaseC;
        "G":     b = BaseG;
        default: b = BaseT;
      endcase
      add_base(b, i == seq.len() - 1);
    end
  endtask

  // Random sequence with whole or cut-short copies of the site planted in it
  task automatic queue_sequence(int unsigned n, int unsigned plant_pct);
    int unsigned i;
    int unsigned cut;
    i = 0;
    while (i < n) begin
      if ($urandom_range(99) < plant_pct && i + plant_len <= n) begin
        cut = ($urandom_range(3) == 0) ? $urandom_range(plant_len, 1) : plant_len;
        for (int k = 0; k < cut; k++)
          add_base(plant_site[2 * (plant_len - 1 - k) +: 2], i + k == n - 1);
        i += cut;
      end else begin
        add_base(BaseW'($urandom_range(3)), i == n - 1);
        i++;
      end
    end
  endtask

  task automatic run_phase(logic [63:0] pattern, logic [LengthW-1:0] len_code,
                           int unsigned n_seq, int unsigned min_len,
                           int unsigned max_len, int unsigned plant_pct);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(RegSitePattern, pattern);
    write_reg(RegSiteLength, {junk[63:LengthW], len_code});
    plant_len  = eff_site_len(len_code);
    plant_site = pattern;
    repeat (n_seq) queue_sequence($urandom_range(max_len, min_len), plant_pct);
    wait_idle();
  endtask

  function automatic logic [63:0] rand_pattern(int unsigned l);
    return {$urandom, $urandom} & site_mask(l);
  endfunction

  initial begin
    logic [63:0] pat;
    int unsigned l;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    // Reset settings: all-A site of four, runs of A, single-base sequence
    queue_bases("AAAAAA");
    queue_bases("T");
    wait_idle();

    // GATC: repeats, a match too early to count, a match on the last base
    write_reg(RegSitePattern, 64'h8D);
    write_reg(RegSiteLength, 64'd4);
    queue_bases("GATCGATCGATCT");
    queue_bases("AGATC");
    wait_idle();

    // Zero length acts as one
    run_phase(rand_pattern(1), 6'd0, 3, 1, 4, 0);
    // Full-width site of all T
    run_phase('1, 6'd32, 1, 34, 38, 50);
    // Length above the maximum acts as the maximum
    run_phase({$urandom, $urandom}, 6'd63, 1, 6, 10, 40);
    // Short site
    run_phase(rand_pattern(3), 6'd3, 3, 1, 8, 25);
    // Pattern bits above the site: never reported
    pat = rand_pattern(5) | (64'd1 << $urandom_range(63, 10));
    run_phase(pat, 6'd5, 2, 1, 8, 40);
    // Mixed lengths
    repeat (2) begin
      l = $urandom_range(8, 1);
      run_phase(rand_pattern(l), LengthW'(l), 1, 1, 8, 30);
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
